// ===== hdl/q2e_pkg.sv =====
package q2e_pkg;

    localparam int ANGLE_FRAC_BITS = 7;
    localparam int ACC_FRAC = 20;
    localparam int ROUND_SHIFT = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam int ROUND_HALF = 1 << (ROUND_SHIFT - 1);

    localparam int QUAT_W = 16;
    localparam int PROD_W = 2 * QUAT_W;
    localparam int TERM_W = PROD_W + 2;
    localparam int S_W = 32;
    localparam int REM_W = 61;
    localparam int ROOT_W = 31;
    localparam int CW = TERM_W + 2;
    localparam int ACC_W = 32;

    localparam int TERM_STAGES = 3;
    localparam int ISQRT_STAGES = ROOT_W;
    localparam int CORDIC_STEPS = 23;
    localparam int CORDIC_STAGES = CORDIC_STEPS + 1;
    localparam int PIPE_DEPTH = TERM_STAGES + ISQRT_STAGES + CORDIC_STAGES + 1;

    localparam logic signed [S_W-1:0] Q30_ONE = S_W'(64'sd1 <<< 30);
    localparam logic signed [ACC_W-1:0] DEG180 = ACC_W'(64'sd180 <<< ACC_FRAC);
    localparam logic signed [ACC_W-1:0] DEG90 = ACC_W'(64'sd90 <<< ACC_FRAC);

    localparam logic signed [ACC_W-1:0] ATAN_TAB [0:CORDIC_STEPS-1] = '{
        32'sd47185920, 32'sd27855475, 32'sd14718068, 32'sd7471121, 32'sd3750058,
        32'sd1876857, 32'sd938658, 32'sd469357, 32'sd234682, 32'sd117342,
        32'sd58671, 32'sd29335, 32'sd14668, 32'sd7334, 32'sd3667, 32'sd1833,
        32'sd917, 32'sd458, 32'sd229, 32'sd115, 32'sd57, 32'sd29, 32'sd14
    };

    typedef struct packed {
        logic clamped;
        logic unit;
        logic neg;
    } pitch_flags_t;

    typedef struct packed {
        logic signed [TERM_W-1:0] rnum;
        logic signed [TERM_W-1:0] rden;
        logic signed [TERM_W-1:0] ynum;
        logic signed [TERM_W-1:0] yden;
        logic signed [S_W-1:0] s;
        pitch_flags_t flags;
    } terms_t;

    // round half up to output units, then saturate to a signed field of width bits
    function automatic logic [15:0] round_sat(input logic signed [ACC_W-1:0] acc,
                                              input int width);
        logic signed [ACC_W:0] sum;
        logic signed [ACC_W:0] v;
        logic signed [ACC_W:0] hi;
        logic signed [ACC_W:0] lo;
        logic signed [ACC_W:0] res;
        sum = $signed({acc[ACC_W-1], acc}) + (ACC_W+1)'(ROUND_HALF);
        v = sum >>> ROUND_SHIFT;
        hi = ((ACC_W+1)'(1) <<< (width - 1)) - (ACC_W+1)'(1);
        lo = -hi - (ACC_W+1)'(1);
        if (v > hi)
        begin
            res = hi;
        end
        else if (v < lo)
        begin
            res = lo;
        end
        else
        begin
            res = v;
        end
        return res[15:0];
    endfunction

endpackage

// ===== hdl/q2e_terms.sv =====
module q2e_terms
    import q2e_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [QUAT_W-1:0] qw,
    input  logic signed [QUAT_W-1:0] qx,
    input  logic signed [QUAT_W-1:0] qy,
    input  logic signed [QUAT_W-1:0] qz,
    output terms_t                   terms,
    output logic        [REM_W-1:0]  rem
);

    logic signed [PROD_W-1:0] wx_reg, yz_reg, xx_reg, yy_reg;
    logic signed [PROD_W-1:0] wz_reg, xy_reg, zz_reg, wy_reg, zx_reg;
    terms_t s2_reg, s2_next;
    terms_t s3_reg;
    logic [REM_W-1:0] rem_reg;
    logic signed [TERM_W-1:0] s_raw;
    logic signed [2*S_W-1:0] sq;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wx_reg <= qw * qx;
            yz_reg <= qy * qz;
            xx_reg <= qx * qx;
            yy_reg <= qy * qy;
            wz_reg <= qw * qz;
            xy_reg <= qx * qy;
            zz_reg <= qz * qz;
            wy_reg <= qw * qy;
            zx_reg <= qz * qx;
        end
    end

    always_comb
    begin
        s2_next.rnum = (TERM_W'(wx_reg) + TERM_W'(yz_reg)) <<< 1;
        s2_next.rden = TERM_W'(Q30_ONE) - ((TERM_W'(xx_reg) + TERM_W'(yy_reg)) <<< 1);
        s2_next.ynum = (TERM_W'(wz_reg) + TERM_W'(xy_reg)) <<< 1;
        s2_next.yden = TERM_W'(Q30_ONE) - ((TERM_W'(yy_reg) + TERM_W'(zz_reg)) <<< 1);
        s_raw = (TERM_W'(wy_reg) - TERM_W'(zx_reg)) <<< 1;
        s2_next.flags.clamped = 1'b0;
        if (s_raw > TERM_W'(Q30_ONE))
        begin
            s2_next.s = Q30_ONE;
            s2_next.flags.clamped = 1'b1;
        end
        else if (s_raw < -TERM_W'(Q30_ONE))
        begin
            s2_next.s = -Q30_ONE;
            s2_next.flags.clamped = 1'b1;
        end
        else
        begin
            s2_next.s = S_W'(s_raw);
        end
        s2_next.flags.unit = (s2_next.s == Q30_ONE) || (s2_next.s == -Q30_ONE);
        s2_next.flags.neg = s2_next.s[S_W-1];
    end

    assign sq = s2_reg.s * s2_reg.s;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_reg <= s2_next;
            s3_reg <= s2_reg;
            rem_reg <= REM_W'(64'd1 << 60) - REM_W'(sq);
        end
    end

    assign terms = s3_reg;
    assign rem = rem_reg;

endmodule

// ===== hdl/q2e_isqrt.sv =====
module q2e_isqrt
    import q2e_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [REM_W-1:0]  rem,
    output logic [ROOT_W-1:0] root
);

    localparam int VW = REM_W + 1;

    logic [VW-1:0] v_reg   [1:ISQRT_STAGES];
    logic [VW-1:0] res_reg [1:ISQRT_STAGES];

    for (genvar k = 0; k < ISQRT_STAGES; k++)
    begin : g_step
        localparam logic [VW-1:0] BIT = VW'(1) << (2 * (ISQRT_STAGES - 1 - k));
        logic [VW-1:0] v_in, res_in, trial;
        if (k == 0)
        begin : g_first
            assign v_in = VW'(rem);
            assign res_in = '0;
        end
        else
        begin : g_rest
            assign v_in = v_reg[k];
            assign res_in = res_reg[k];
        end
        assign trial = res_in + BIT;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (v_in >= trial)
                begin
                    v_reg[k+1] <= v_in - trial;
                    res_reg[k+1] <= (res_in >> 1) + BIT;
                end
                else
                begin
                    v_reg[k+1] <= v_in;
                    res_reg[k+1] <= res_in >> 1;
                end
            end
        end
    end

    assign root = res_reg[ISQRT_STAGES][ROOT_W-1:0];

endmodule

// ===== hdl/q2e_cordic.sv =====
module q2e_cordic
    import q2e_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [TERM_W-1:0] y_in,
    input  logic signed [TERM_W-1:0] x_in,
    output logic signed [ACC_W-1:0]  angle
);

    logic signed [CW-1:0]    x_reg [0:CORDIC_STEPS];
    logic signed [CW-1:0]    y_reg [0:CORDIC_STEPS];
    logic signed [ACC_W-1:0] z_reg [0:CORDIC_STEPS];

    // fold the left half plane onto the right one
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (x_in < 0)
            begin
                x_reg[0] <= -CW'(x_in);
                y_reg[0] <= -CW'(y_in);
                z_reg[0] <= (y_in >= 0) ? DEG180 : -DEG180;
            end
            else
            begin
                x_reg[0] <= CW'(x_in);
                y_reg[0] <= CW'(y_in);
                z_reg[0] <= '0;
            end
        end
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_step
        logic signed [CW-1:0] xs, ys;
        assign xs = x_reg[k] >>> k;
        assign ys = y_reg[k] >>> k;
        // a zero y holds the vector, which matches stopping early
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (y_reg[k] > 0)
                begin
                    x_reg[k+1] <= x_reg[k] + ys;
                    y_reg[k+1] <= y_reg[k] - xs;
                    z_reg[k+1] <= z_reg[k] + ATAN_TAB[k];
                end
                else if (y_reg[k] < 0)
                begin
                    x_reg[k+1] <= x_reg[k] - ys;
                    y_reg[k+1] <= y_reg[k] + xs;
                    z_reg[k+1] <= z_reg[k] - ATAN_TAB[k];
                end
                else
                begin
                    x_reg[k+1] <= x_reg[k];
                    y_reg[k+1] <= y_reg[k];
                    z_reg[k+1] <= z_reg[k];
                end
            end
        end
    end

    assign angle = z_reg[CORDIC_STEPS];

endmodule

// ===== hdl/quaternion_to_euler_angles_top.sv =====
// Converts a stream of Q1.15 quaternions (w, x, y, z) to ZYX Euler angles: roll, pitch and
// yaw in signed steps of 1/2^ANGLE_FRAC_BITS degree, with pitch held at +-90 degrees and
// pitch_clamped set when |2(wy - zx)| exceeds one. One request is taken every cycle in which
// in_stall is low. A request passes through the products and sums, the one-bit-per-stage
// square root for the pitch cosine, the three parallel CORDIC pipelines and one output
// rounding stage, in that order. While a result is waiting, a held out_stall freezes the
// whole pipeline and in_stall follows it.
module quaternion_to_euler_angles_top
    import q2e_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [QUAT_W-1:0] quat_w,
    input  logic signed [QUAT_W-1:0] quat_x,
    input  logic signed [QUAT_W-1:0] quat_y,
    input  logic signed [QUAT_W-1:0] quat_z,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [15:0]       roll_angle,
    output logic signed [14:0]       pitch_angle,
    output logic signed [15:0]       yaw_angle,
    output logic                     pitch_clamped
);

    logic adv;
    logic valid_reg [0:PIPE_DEPTH-1];

    terms_t terms;
    logic [REM_W-1:0] rem;
    logic [ROOT_W-1:0] root;
    terms_t side_reg [1:ISQRT_STAGES];
    pitch_flags_t flag_reg [1:CORDIC_STAGES];
    logic signed [ACC_W-1:0] roll_acc, pitch_acc, yaw_acc, pitch_sel;

    logic signed [15:0] roll_reg, yaw_reg;
    logic signed [14:0] pitch_reg;
    logic clamped_reg;

    assign out_valid = valid_reg[PIPE_DEPTH-1];
    assign in_stall = out_valid && out_stall;
    assign adv = !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PIPE_DEPTH; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i < PIPE_DEPTH; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    q2e_terms u_terms (
        .clk   (clk),
        .en    (adv),
        .qw    (quat_w),
        .qx    (quat_x),
        .qy    (quat_y),
        .qz    (quat_z),
        .terms (terms),
        .rem   (rem)
    );

    q2e_isqrt u_isqrt (
        .clk  (clk),
        .en   (adv),
        .rem  (rem),
        .root (root)
    );

    // keep the roll and yaw terms aligned with the square root
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[1] <= terms;
            for (int i = 2; i <= ISQRT_STAGES; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
            flag_reg[1] <= side_reg[ISQRT_STAGES].flags;
            for (int i = 2; i <= CORDIC_STAGES; i++)
            begin
                flag_reg[i] <= flag_reg[i-1];
            end
        end
    end

    q2e_cordic u_roll (
        .clk   (clk),
        .en    (adv),
        .y_in  (side_reg[ISQRT_STAGES].rnum),
        .x_in  (side_reg[ISQRT_STAGES].rden),
        .angle (roll_acc)
    );

    q2e_cordic u_pitch (
        .clk   (clk),
        .en    (adv),
        .y_in  (TERM_W'(side_reg[ISQRT_STAGES].s)),
        .x_in  ($signed(TERM_W'(root))),
        .angle (pitch_acc)
    );

    q2e_cordic u_yaw (
        .clk   (clk),
        .en    (adv),
        .y_in  (side_reg[ISQRT_STAGES].ynum),
        .x_in  (side_reg[ISQRT_STAGES].yden),
        .angle (yaw_acc)
    );

    // a unit argument gives exactly +-90 degrees
    always_comb
    begin
        if (flag_reg[CORDIC_STAGES].unit)
        begin
            pitch_sel = flag_reg[CORDIC_STAGES].neg ? -DEG90 : DEG90;
        end
        else
        begin
            pitch_sel = pitch_acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            roll_reg <= round_sat(roll_acc, 16);
            pitch_reg <= 15'(round_sat(pitch_sel, 15));
            yaw_reg <= round_sat(yaw_acc, 16);
            clamped_reg <= flag_reg[CORDIC_STAGES].clamped;
        end
    end

    assign roll_angle = roll_reg;
    assign pitch_angle = pitch_reg;
    assign yaw_angle = yaw_reg;
    assign pitch_clamped = clamped_reg;

endmodule
